FILE: rtl/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

    // datapath operations, one per controller step
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ML,
        OP_MR,
        OP_VL,
        OP_VR,
        OP_VX,
        OP_DA,
        OP_DLO,
        OP_DHI,
        OP_DIST,
        OP_WA,
        OP_ALO,
        OP_AHI,
        OP_ANG,
        OP_DX,
        OP_DY,
        OP_UPD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cor_done;
    } sts_t;

    // configuration register indexes
    localparam int CFG_AW = 8;
    localparam logic [CFG_AW-1:0] REG_RADIUS = 8'd0;
    localparam logic [CFG_AW-1:0] REG_BASE   = 8'd1;

    localparam logic [15:0] RADIUS_RST = 16'd3277;
    localparam logic [23:0] BASE_RST   = 24'd32768;

    // fixed-point constants
    localparam logic [31:0] TWO_PI_Q28  = 32'd1686629713;
    localparam logic [31:0] DIST_K      = 32'd2251799814;
    localparam logic [31:0] ANG_K       = 32'd2867080570;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

    // arctangent of 2^-i as binary angle
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/odo_div.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [44:0] num,
    input  wire logic [23:0] den,
    output logic [44:0]      quo,
    output logic             done
);
    logic [44:0] nq_reg, nq_next;
    logic [24:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] rem_sh;
    logic        ge;

    // restoring division, one quotient bit a cycle
    always_comb begin
        rem_sh    = {rem_reg[23:0], nq_reg[44]};
        ge        = (rem_sh >= {1'b0, den});
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            nq_next   = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            nq_next  = {nq_reg[43:0], ge};
            rem_next = ge ? (rem_sh - {1'b0, den}) : rem_sh;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd44) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quo  = nq_reg;
    assign done = done_reg;
endmodule
`default_nettype wire

FILE: rtl/odo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_cordic #(
    parameter int STEPS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [31:0]        angle,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out,
    output logic                    done
);
    import odo_pkg::*;

    localparam int CW = $clog2(STEPS + 1);

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [CW-1:0]      i_reg, i_next;
    logic               flip_reg, flip_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic signed [31:0] ang_s, ang_r;
    logic               fold;
    logic [4:0]         aidx;
    logic signed [33:0] at;

    // fold into the right half plane, then one rotation a cycle
    always_comb begin
        ang_s     = signed'(angle);
        ang_r     = signed'(angle + 32'h8000_0000);
        fold      = (ang_s > 32'sd1073741824) || (ang_s < -32'sd1073741824);
        aidx      = 5'(i_reg);
        at        = signed'({2'b00, atan_bam(aidx)});
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            x_next    = signed'({2'b00, CORDIC_GAIN});
            y_next    = '0;
            z_next    = fold ? 34'(ang_r) : 34'(ang_s);
            i_next    = '0;
            flip_next = fold;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (z_reg >= 0) begin
                x_next = x_reg - (y_reg >>> i_reg);
                y_next = y_reg + (x_reg >>> i_reg);
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + (y_reg >>> i_reg);
                y_next = y_reg - (x_reg >>> i_reg);
                z_next = z_reg + at;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == CW'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        flip_reg <= flip_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
    assign done    = done_reg;
endmodule
`default_nettype wire

FILE: rtl/odo_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_datapath #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire odo_pkg::cmd_t               cmd,
    output odo_pkg::sts_t                    sts,
    input  wire logic [55:0]                 s_tdata,
    input  wire logic                        cfg_valid,
    input  wire logic [odo_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic [31:0]                 cfg_data,
    output logic [159:0]                     m_tdata
);
    import odo_pkg::*;

    // configuration
    logic [15:0] rad_reg;
    logic [23:0] base_reg;

    // item and intermediate values
    logic signed [15:0] ls_reg, rs_reg;
    logic [19:0]        dt_reg;
    logic signed [32:0] ml_reg, mr_reg;
    logic signed [35:0] vl_reg, vr_reg;
    logic signed [31:0] vx_reg, wq_reg;
    logic               wq_neg_reg;
    logic [51:0]        a_reg;
    logic [63:0]        lo_reg;
    logic [51:0]        hi_reg;
    logic signed [34:0] dist_reg;
    logic [31:0]        dang_reg;
    logic signed [35:0] dx_reg, dy_reg;

    // pose state and output register
    logic signed [31:0] x_reg, y_reg;
    logic [31:0]        hd_reg;
    logic [159:0]       out_reg;

    // shared multiplier
    logic signed [35:0] mul_a, mul_b;
    logic signed [71:0] prod, prod_r28, prod_r30;

    logic signed [36:0] vsum, diff;
    logic [35:0]        dmag;
    logic [23:0]        base_eff;
    logic [44:0]        div_num, quo;
    logic               div_done, cor_done, div_start;
    logic signed [33:0] cos_v, sin_v;
    logic signed [31:0] wq_c;
    logic [31:0]        wq_mag, vx_mag;
    logic [53:0]        mid, mid_d, mid_a;
    logic [31:0]        am;
    logic [33:0]        dm;
    logic signed [36:0] sx, sy;
    logic signed [31:0] x_sat, y_sat;

    assign vx_mag = vx_reg[31] ? 32'(-vx_reg) : 32'(vx_reg);

    // operand selection for the one multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_ML: begin
                mul_a = 36'(ls_reg);
                mul_b = signed'({20'b0, rad_reg});
            end
            OP_MR: begin
                mul_a = 36'(rs_reg);
                mul_b = signed'({20'b0, rad_reg});
            end
            OP_VL: begin
                mul_a = 36'(ml_reg);
                mul_b = signed'({4'b0, TWO_PI_Q28});
            end
            OP_VR: begin
                mul_a = 36'(mr_reg);
                mul_b = signed'({4'b0, TWO_PI_Q28});
            end
            OP_DA: begin
                mul_a = signed'({4'b0, vx_mag});
                mul_b = signed'({16'b0, dt_reg});
            end
            OP_DLO: begin
                mul_a = signed'({4'b0, a_reg[31:0]});
                mul_b = signed'({4'b0, DIST_K});
            end
            OP_DHI: begin
                mul_a = signed'({16'b0, a_reg[51:32]});
                mul_b = signed'({4'b0, DIST_K});
            end
            OP_WA: begin
                mul_a = signed'({4'b0, wq_mag});
                mul_b = signed'({16'b0, dt_reg});
            end
            OP_ALO: begin
                mul_a = signed'({4'b0, a_reg[31:0]});
                mul_b = signed'({4'b0, ANG_K});
            end
            OP_AHI: begin
                mul_a = signed'({16'b0, a_reg[51:32]});
                mul_b = signed'({4'b0, ANG_K});
            end
            OP_DX: begin
                mul_a = 36'(dist_reg);
                mul_b = 36'(cos_v);
            end
            OP_DY: begin
                mul_a = 36'(dist_reg);
                mul_b = 36'(sin_v);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_r28 = prod + 72'sd134217728;
    assign prod_r30 = prod + 72'sd536870912;

    // forward speed never leaves 32 bits, so no clamp is needed there
    assign vsum     = 37'(vl_reg) + 37'(vr_reg) + 37'sd256;
    assign diff     = 37'(vr_reg) - 37'(vl_reg);
    assign dmag     = diff[36] ? 36'(-diff) : 36'(diff);
    assign base_eff = (base_reg == 24'd0) ? 24'd1 : base_reg;
    assign div_num  = {1'b0, dmag, 8'b0} + {22'b0, base_eff[23:1]};
    assign div_start = (cmd.op == OP_VX);

    // yaw rate: clamp the quotient and restore the sign
    always_comb begin
        if (quo >= 45'h0_8000_0000) begin
            wq_c   = wq_neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            wq_mag = wq_neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            wq_c   = wq_neg_reg ? -signed'(quo[31:0]) : signed'(quo[31:0]);
            wq_mag = quo[31:0];
        end
    end

    // scale by constant, low partial product trimmed to its upper word
    assign mid   = {2'b0, hi_reg} + {22'b0, lo_reg[63:32]};
    assign mid_d = mid + 54'd262144;
    assign mid_a = mid + 54'd32;
    assign dm    = mid_d[52:19];
    assign am    = mid_a[37:6];

    // saturating position update
    assign sx    = 37'(x_reg) + 37'(dx_reg);
    assign sy    = 37'(y_reg) + 37'(dy_reg);
    assign x_sat = (sx > 37'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (sx < -37'sh0_8000_0000) ? 32'sh8000_0000 : sx[31:0];
    assign y_sat = (sy > 37'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (sy < -37'sh0_8000_0000) ? 32'sh8000_0000 : sy[31:0];

    // step registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                ls_reg <= signed'(s_tdata[15:0]);
                rs_reg <= signed'(s_tdata[31:16]);
                dt_reg <= s_tdata[51:32];
            end
            OP_ML:   ml_reg <= prod[32:0];
            OP_MR:   mr_reg <= prod[32:0];
            OP_VL:   vl_reg <= prod_r28[63:28];
            OP_VR:   vr_reg <= prod_r28[63:28];
            OP_VX: begin
                vx_reg     <= 32'(vsum >>> 9);
                wq_neg_reg <= diff[36];
            end
            OP_DA:   a_reg  <= prod[51:0];
            OP_DLO:  lo_reg <= prod[63:0];
            OP_DHI:  hi_reg <= prod[51:0];
            OP_DIST: dist_reg <= vx_reg[31] ? -signed'({1'b0, dm}) : signed'({1'b0, dm});
            OP_WA: begin
                wq_reg <= wq_c;
                a_reg  <= prod[51:0];
            end
            OP_ALO:  lo_reg <= prod[63:0];
            OP_AHI:  hi_reg <= prod[51:0];
            OP_ANG:  dang_reg <= wq_neg_reg ? (32'd0 - am) : am;
            OP_DX:   dx_reg <= prod_r30[65:30];
            OP_DY:   dy_reg <= prod_r30[65:30];
            OP_UPD:  out_reg <= {wq_reg, vx_reg, hd_reg + dang_reg, y_sat, x_sat};
            default: ;
        endcase
    end

    // pose and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg    <= '0;
            y_reg    <= '0;
            hd_reg   <= '0;
            rad_reg  <= RADIUS_RST;
            base_reg <= BASE_RST;
        end else begin
            if (cmd.op == OP_UPD) begin
                x_reg  <= x_sat;
                y_reg  <= y_sat;
                hd_reg <= hd_reg + dang_reg;
            end
            if (cfg_valid) begin
                if (cfg_addr == REG_RADIUS) rad_reg <= cfg_data[15:0];
                else if (cfg_addr == REG_BASE) base_reg <= cfg_data[23:0];
            end
        end
    end

    odo_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (base_eff),
        .quo     (quo),
        .done    (div_done)
    );

    odo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .angle   (hd_reg),
        .cos_out (cos_v),
        .sin_out (sin_v),
        .done    (cor_done)
    );

    assign sts.div_done = div_done;
    assign sts.cor_done = cor_done;
    assign m_tdata      = out_reg;
endmodule
`default_nettype wire

FILE: rtl/odo_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output odo_pkg::cmd_t      cmd,
    input  wire odo_pkg::sts_t sts
);
    import odo_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ML, ST_MR, ST_VL, ST_VR, ST_VX, ST_DA, ST_DLO, ST_DHI,
        ST_DIST, ST_WAIT, ST_WA, ST_ALO, ST_AHI, ST_ANG, ST_DX, ST_DY, ST_UPD
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   upd_go;

    assign upd_go = !out_valid_reg || m_tready;

    // sequence and command decode
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: if (s_tvalid) begin
                cmd.op = OP_LOAD;
                state_next = ST_ML;
            end
            ST_ML:   begin cmd.op = OP_ML;   state_next = ST_MR;   end
            ST_MR:   begin cmd.op = OP_MR;   state_next = ST_VL;   end
            ST_VL:   begin cmd.op = OP_VL;   state_next = ST_VR;   end
            ST_VR:   begin cmd.op = OP_VR;   state_next = ST_VX;   end
            ST_VX:   begin cmd.op = OP_VX;   state_next = ST_DA;   end
            ST_DA:   begin cmd.op = OP_DA;   state_next = ST_DLO;  end
            ST_DLO:  begin cmd.op = OP_DLO;  state_next = ST_DHI;  end
            ST_DHI:  begin cmd.op = OP_DHI;  state_next = ST_DIST; end
            ST_DIST: begin cmd.op = OP_DIST; state_next = ST_WAIT; end
            ST_WAIT: if (sts.div_done && sts.cor_done) begin
                state_next = ST_WA;
            end
            ST_WA:   begin cmd.op = OP_WA;   state_next = ST_ALO;  end
            ST_ALO:  begin cmd.op = OP_ALO;  state_next = ST_AHI;  end
            ST_AHI:  begin cmd.op = OP_AHI;  state_next = ST_ANG;  end
            ST_ANG:  begin cmd.op = OP_ANG;  state_next = ST_DX;   end
            ST_DX:   begin cmd.op = OP_DX;   state_next = ST_DY;   end
            ST_DY:   begin cmd.op = OP_DY;   state_next = ST_UPD;  end
            ST_UPD: if (upd_go) begin
                cmd.op = OP_UPD;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output item valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) out_valid_next = 1'b0;
        if (state_reg == ST_UPD && upd_go) out_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    // a new result only comes from the update step
    a_rise_from_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_UPD))
        else $error("result valid without update step");

    // waiting holds until both units finish
    a_wait_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && !(sts.div_done && sts.cor_done)) |=> state_reg == ST_WAIT)
        else $error("left wait before units finished");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && out_valid_reg && !m_tready) |=> state_reg == ST_UPD)
        else $error("update while result pending");

    // an accepted item always starts the sequence
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_ML)
        else $error("accepted item did not start");
endmodule
`default_nettype wire

FILE: rtl/diff_drive_odometry_integrator.sv
`timescale 1ns / 1ps
`default_nettype none
// an accepted item passes the multiply steps ML, MR, VL and VR; VX then starts the bit-serial
// yaw-rate divider, which the CORDIC and the steps DA to DIST overlap; once both finish, 7 steps follow
// a new item is taken only after the update step of the last; a finished result may wait in the output register
// while the next item is worked on, and a result still pending holds the update step
// reset: synchronous active-low aresetn clears pose, heading and handshakes and
// restores the radius register to 3277 and the base register to 32768
module diff_drive_odometry_integrator #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // left_speed[15:0], right_speed[31:16], elapsed_us[51:32], zero pad [55:52]
    input  wire logic [55:0]                s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // pos_x[31:0], pos_y[63:32], heading[95:64], lin_velocity[127:96],
    // yaw_rate[159:128]
    output logic [159:0]                    m_tdata,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [odo_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [31:0]                cfg_data
);
    import odo_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    odo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    odo_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire
